// ===== src/i2ctcb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ctcb_pkg
// Shared types and codes for the I2C target command buffer.
// ----------------------------------------------------------------------------
package i2ctcb_pkg;

  // Bus event codes carried in cmd
  localparam logic [2:0] EV_ADDR = 3'd0;
  localparam logic [2:0] EV_RX   = 3'd1;
  localparam logic [2:0] EV_TX   = 3'd2;
  localparam logic [2:0] EV_STOP = 3'd3;
  localparam logic [2:0] EV_NACK = 3'd4;

  typedef enum logic [2:0] {
    PH_READY,
    PH_GET_PTR,
    PH_PTR_HELD,
    PH_WR_DATA,
    PH_RD_DATA
  } phase_t;

  // Result of one event as it leaves the control core
  typedef struct packed {
    logic       use_ram;        // tx byte comes from the store RAM
    logic       ram_hit;        // addressed RAM entry has been written
    logic [7:0] tx_byte;        // tx byte when it does not come from RAM
    logic       command_ready;
    logic [5:0] byte_count;
  } res_t;

endpackage

// ===== src/i2ctcb_if.sv =====
// ----------------------------------------------------------------------------
// i2ctcb_if
// Valid/ready channels for bus events in and results out.
// ----------------------------------------------------------------------------
interface i2ctcb_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       read_dir;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output read_dir, output rx_byte, input ready);
  modport sink (input valid, input cmd, input read_dir, input rx_byte, output ready);
endinterface

interface i2ctcb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       command_ready;
  logic [5:0] byte_count;

  modport source (output valid, output tx_byte, output command_ready, output byte_count,
                  input ready);
  modport sink (input valid, input tx_byte, input command_ready, input byte_count,
                output ready);
endinterface

// ===== src/i2ctcb_ram.sv =====
// ----------------------------------------------------------------------------
// i2ctcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2ctcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/i2ctcb_core.sv =====
// ----------------------------------------------------------------------------
// i2ctcb_core
// Transaction state, pointer, transfer count, slot 0 and RAM valid bits.
// Decodes one bus event per cycle, when the event is taken, into store writes, a store read and a result.
// ----------------------------------------------------------------------------
module i2ctcb_core #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [2:0]                   cmd,
  input  logic                         read_dir,
  input  logic [7:0]                   rx_byte,
  output i2ctcb_pkg::res_t             res,
  output logic                         wr_en,
  output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  output logic [7:0]                   wr_data,
  output logic                         rd_en,
  output logic [$clog2(BUF_DEPTH)-1:0] rd_addr
);
  import i2ctcb_pkg::*;

  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

  phase_t             phase, phase_next;
  logic [7:0]         pointer, pointer_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [7:0]         slot0, slot0_next;
  logic               slot0_we;
  logic [BUF_DEPTH-1:0] vld;
  logic               ram_we, ram_re;
  logic               cnt_free;
  logic [SUM_W-1:0]   idx;
  logic               idx_ok;
  logic [SUM_W-1:0]   cnt_ext;

  assign cnt_free = count < CNT_W'(BUF_DEPTH);
  assign idx      = SUM_W'(pointer) + SUM_W'(count);
  assign idx_ok   = idx < SUM_W'(BUF_DEPTH);
  assign cnt_ext  = SUM_W'(count_next);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (cmd)
      EV_ADDR: phase_next = read_dir ? PH_RD_DATA : PH_GET_PTR;
      EV_RX: begin
        if (phase == PH_GET_PTR) begin
          phase_next = PH_PTR_HELD;
        end else if (phase == PH_PTR_HELD) begin
          phase_next = PH_WR_DATA;
        end
      end
      EV_STOP: phase_next = PH_READY;
      EV_NACK: phase_next = PH_READY;
      default: phase_next = phase;
    endcase
  end

  // Data path: store writes, store read and result
  always_comb begin
    pointer_next  = pointer;
    count_next    = count;
    slot0_we      = 1'b0;
    slot0_next    = rx_byte;
    ram_we        = 1'b0;
    wr_addr       = count[ADDR_W-1:0];
    wr_data       = rx_byte;
    ram_re        = 1'b0;
    rd_addr       = idx[ADDR_W-1:0];
    res.use_ram   = 1'b0;
    res.ram_hit   = 1'b0;
    res.tx_byte   = 8'h00;
    res.command_ready = 1'b0;
    case (cmd)
      EV_ADDR: begin
        count_next = '0;
        if (!read_dir || phase == PH_READY) begin
          pointer_next = 8'h00;
        end
      end
      EV_RX: begin
        if (phase == PH_GET_PTR) begin
          pointer_next = rx_byte;
        end else if (phase == PH_PTR_HELD) begin
          // count is zero here: pointer goes to slot 0, the byte to slot 1
          if (cnt_free) begin
            slot0_we   = 1'b1;
            slot0_next = pointer;
            ram_we     = 1'b1;
            wr_addr    = ADDR_W'(1);
            count_next = CNT_W'(2);
          end
        end else if (cnt_free) begin
          if (count == '0) begin
            slot0_we = 1'b1;
          end else begin
            ram_we = 1'b1;
          end
          count_next = count + CNT_W'(1);
        end
      end
      EV_TX: begin
        if (phase == PH_RD_DATA && idx_ok) begin
          if (idx == '0) begin
            res.tx_byte = slot0;
          end else begin
            ram_re      = 1'b1;
            res.use_ram = 1'b1;
            res.ram_hit = vld[rd_addr];
          end
          count_next = count + CNT_W'(1);
        end
      end
      EV_STOP: begin
        // lone pointer becomes a one-byte command
        if (phase == PH_PTR_HELD && cnt_free) begin
          wr_data    = pointer;
          slot0_next = pointer;
          if (count == '0) begin
            slot0_we = 1'b1;
          end else begin
            ram_we = 1'b1;
          end
          count_next = count + CNT_W'(1);
        end
        res.command_ready = (count_next != '0);
      end
      default: begin
      end
    endcase
    res.byte_count = cnt_ext[5:0];
  end

  assign wr_en = take & ram_we;
  assign rd_en = take & ram_re;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_READY;
      pointer <= 8'h00;
      count   <= '0;
      slot0   <= 8'h00;
      vld     <= '0;
    end else if (take) begin
      phase   <= phase_next;
      pointer <= pointer_next;
      count   <= count_next;
      if (slot0_we) begin
        slot0 <= slot0_next;
      end
      if (ram_we) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

// ===== src/i2ctcb_top_stage.sv =====
// ----------------------------------------------------------------------------
// i2ctcb_top_stage
// Output register: holds one result beat and merges in the RAM read data.
// ----------------------------------------------------------------------------
module i2ctcb_top_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  i2ctcb_pkg::res_t res,
  input  logic [7:0]       ram_rdata,
  output logic             busy,
  output i2ctcb_pkg::res_t res_q,
  i2ctcb_res_if.source     rsp
);
  import i2ctcb_pkg::*;

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  // Slot never written reads as zero
  assign rsp.valid         = out_valid;
  assign rsp.tx_byte       = res_q.use_ram ? (res_q.ram_hit ? ram_rdata : 8'h00)
                                           : res_q.tx_byte;
  assign rsp.command_ready = res_q.command_ready;
  assign rsp.byte_count    = res_q.byte_count;
  assign busy              = out_valid & ~rsp.ready;

endmodule

// ===== src/i2c_target_command_buffer.sv =====
// ----------------------------------------------------------------------------
// i2c_target_command_buffer
// Byte-level I2C target event handler over a BUF_DEPTH-byte command store.
// A result beat is valid in the cycle after its event beat is taken.
// Throughput: one event per cycle while the result side is ready; the store RAM takes one write or one read.
// Reset: synchronous; phase, pointer, count and store contents read as zero.
// ----------------------------------------------------------------------------
module i2c_target_command_buffer #(
  parameter int BUF_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  i2ctcb_evt_if.sink   req,
  i2ctcb_res_if.source rsp
);
  import i2ctcb_pkg::*;

  localparam int ADDR_W = $clog2(BUF_DEPTH);

  logic              take;
  logic              busy;
  res_t              res, res_q;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, ram_rdata;

  assign req.ready = ~busy;
  assign take      = req.valid & req.ready;

  i2ctcb_core #(.BUF_DEPTH(BUF_DEPTH)) u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (req.cmd),
    .read_dir (req.read_dir),
    .rx_byte  (req.rx_byte),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  i2ctcb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  i2ctcb_top_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res       (res),
    .ram_rdata (ram_rdata),
    .busy      (busy),
    .res_q     (res_q),
    .rsp       (rsp)
  );

  // Store port is touched only by a taken event beat
  a_rd_on_take : assert property (@(posedge clk) disable iff (rst) rd_en |-> take)
    else $error("store read without a taken event");

  a_one_port_op : assert property (@(posedge clk) disable iff (rst) !(wr_en && rd_en))
    else $error("store read and write in one cycle");

  // A stalled result keeps its register and the byte it presents
  a_hold_result : assert property (@(posedge clk) disable iff (rst)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(res_q) && $stable(rsp.tx_byte)))
    else $error("stalled result changed");

  a_ram_result : assert property (@(posedge clk) disable iff (rst)
      rd_en |=> (rsp.valid && res_q.use_ram))
    else $error("RAM read not paired with its result");

endmodule

// ===== dv/i2c_target_command_buffer_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_target_command_buffer_checker
// Watches the event and result channels of the I2C target command buffer and
// keeps its own copy of the phase, pointer, count and command store. Each
// accepted event pushes the result it should cause. Each accepted result beat
// is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module i2c_target_command_buffer_checker #(
  parameter int BUF_DEPTH = 32
) (
  input  logic   clk,
  input  logic   rst,
  i2ctcb_evt_if  evt,
  i2ctcb_res_if  res,
  output int     mismatches,
  output int     outstanding
);
  import i2ctcb_pkg::*;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       command_ready;
    logic [5:0] byte_count;
  } bus_result_t;

  phase_t      bus_phase;
  logic [7:0]  reg_ptr;
  int unsigned xfer_count;
  logic [7:0]  cmd_store [BUF_DEPTH];
  bus_result_t due_results [$];

  function automatic void clear_model();
    bus_phase  = PH_READY;
    reg_ptr    = '0;
    xfer_count = 0;
    foreach (cmd_store[i]) cmd_store[i] = '0;
  endfunction

  // Drop the byte once the store is full
  function automatic void store_byte(logic [7:0] b);
    if (xfer_count < BUF_DEPTH) begin
      cmd_store[xfer_count] = b;
      xfer_count++;
    end
  endfunction

  function automatic bus_result_t apply_bus_event(logic [2:0] ev, logic dir, logic [7:0] rx);
    bus_result_t r;
    int unsigned slot;
    r = '0;
    case (ev)
      EV_ADDR: begin
        xfer_count = 0;
        if (!dir) begin
          reg_ptr   = '0;
          bus_phase = PH_GET_PTR;
        end else begin
          // repeated start keeps the pointer
          if (bus_phase == PH_READY) reg_ptr = '0;
          bus_phase = PH_RD_DATA;
        end
      end
      EV_RX: begin
        if (bus_phase == PH_GET_PTR) begin
          reg_ptr   = rx;
          bus_phase = PH_PTR_HELD;
        end else if (bus_phase == PH_PTR_HELD) begin
          if (xfer_count < BUF_DEPTH) begin
            store_byte(reg_ptr);
            store_byte(rx);
          end
          bus_phase = PH_WR_DATA;
        end else begin
          store_byte(rx);
        end
      end
      EV_TX: begin
        if (bus_phase == PH_RD_DATA) begin
          slot = reg_ptr + xfer_count;
          if (slot < BUF_DEPTH) begin
            r.tx_byte = cmd_store[slot];
            xfer_count++;
          end
        end
      end
      EV_STOP: begin
        // lone pointer becomes a one-byte command
        if (bus_phase == PH_PTR_HELD) store_byte(reg_ptr);
        r.command_ready = (xfer_count != 0);
        bus_phase = PH_READY;
      end
      EV_NACK: bus_phase = PH_READY;
      default: ;
    endcase
    r.byte_count = xfer_count[5:0];
    return r;
  endfunction

  function automatic void flag_mismatch(string what, bus_result_t want, bus_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected tx_byte=%02h command_ready=%0b byte_count=%0d, got tx_byte=%02h command_ready=%0b byte_count=%0d",
               $time, what, want.tx_byte, want.command_ready, want.byte_count,
               seen.tx_byte, seen.command_ready, seen.byte_count);
    end
  endfunction

  always @(posedge clk) begin
    bus_result_t seen;
    bus_result_t want;
    if (rst) begin
      clear_model();
      due_results.delete();
      mismatches = 0;
    end else begin
      if (res.valid && res.ready) begin
        seen = '{res.tx_byte, res.command_ready, res.byte_count};
        if (due_results.size() == 0) begin
          flag_mismatch("result beat with nothing due", '0, seen);
        end else begin
          want = due_results.pop_front();
          if (seen.tx_byte !== want.tx_byte || seen.command_ready !== want.command_ready ||
              seen.byte_count !== want.byte_count) begin
            flag_mismatch("result beat differs", want, seen);
          end
        end
      end
      if (evt.valid && evt.ready) begin
        due_results.push_back(apply_bus_event(evt.cmd, evt.read_dir, evt.rx_byte));
      end
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== dv/i2c_target_command_buffer_test.sv =====
// ----------------------------------------------------------------------------
// i2c_target_command_buffer_test
// Drives bus events into the I2C target command buffer: a directed pass over
// the corner cases, then random write, read and repeated-start transactions
// mixed with noise, with random gaps on the event side and random stalls on
// the result side. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module i2c_target_command_buffer_test;
  import i2ctcb_pkg::*;

  localparam int BUF_DEPTH = 32;
  localparam int EVENT_GOAL = 1500;

  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  // codes the block ignores
  localparam logic [2:0] EV_SPARE_A = 3'd5;
  localparam logic [2:0] EV_SPARE_B = 3'd6;
  localparam logic [2:0] EV_SPARE_C = 3'd7;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches;
  int   outstanding;
  int   events_sent;

  i2ctcb_evt_if evt ();
  i2ctcb_res_if res ();

  i2c_target_command_buffer #(.BUF_DEPTH(BUF_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (evt.sink),
    .rsp (res.source)
  );

  i2c_target_command_buffer_checker #(.BUF_DEPTH(BUF_DEPTH)) u_check (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Hold valid across back-to-back beats; lower it only for a gap
  task automatic drive_event(input logic [2:0] ev, input logic dir, input logic [7:0] rx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt.valid    <= 1'b1;
    evt.cmd      <= ev;
    evt.read_dir <= dir;
    evt.rx_byte  <= rx;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    if (ev <= EV_NACK) events_sent++;
  endtask

  task automatic send_addr(input logic dir);
    drive_event(EV_ADDR, dir, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_event(EV_RX, 1'($urandom), b);
  endtask

  task automatic ask_byte();
    drive_event(EV_TX, 1'($urandom), 8'($urandom));
  endtask

  task automatic send_stop();
    drive_event(EV_STOP, 1'($urandom), 8'($urandom));
  endtask

  task automatic send_nack();
    drive_event(EV_NACK, 1'($urandom), 8'($urandom));
  endtask

  // Mostly stop, sometimes nack, sometimes leave the transaction open
  task automatic close_transaction();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) send_stop();
    else if (pick == 8) send_nack();
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, BUF_DEPTH + 8);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] pick_pointer();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, BUF_DEPTH + 2));
  endfunction

  // Result side: stall a random number of cycles before each beat
  initial begin
    int stall;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
    end
  end

  initial begin
    int n;
    rst          <= 1'b1;
    evt.valid    <= 1'b0;
    evt.cmd      <= EV_ADDR;
    evt.read_dir <= DIR_WRITE;
    evt.rx_byte  <= '0;
    calm         = 1'b0;
    events_sent  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // idle events, and codes the block ignores
    send_stop();
    ask_byte();
    send_nack();
    drive_event(EV_SPARE_A, DIR_READ, 8'hFF);
    drive_event(EV_SPARE_B, DIR_WRITE, 8'h00);
    drive_event(EV_SPARE_C, DIR_READ, 8'h5A);

    // write: pointer then data, stop flags the command
    send_addr(DIR_WRITE);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_stop();

    // lone pointer
    send_addr(DIR_WRITE);
    send_byte(8'h55);
    send_stop();

    // read from idle starts at slot zero
    send_addr(DIR_READ);
    ask_byte();
    ask_byte();
    send_stop();

    // repeated start keeps the pointer; second read runs past the end
    send_addr(DIR_WRITE);
    send_byte(8'(BUF_DEPTH - 1));
    send_addr(DIR_READ);
    ask_byte();
    ask_byte();
    send_nack();

    // bytes outside a write
    send_byte(8'h34);
    send_addr(DIR_READ);
    send_byte(8'h12);
    send_stop();

    while (events_sent < EVENT_GOAL) begin
      calm = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_addr(DIR_WRITE);
          send_byte(pick_pointer());
          n = pick_length();
          repeat (n) send_byte(8'($urandom));
          close_transaction();
        end
        4, 5: begin
          send_addr(DIR_WRITE);
          send_byte(pick_pointer());
          send_addr(DIR_READ);
          n = pick_length();
          repeat (n) ask_byte();
          close_transaction();
        end
        6: begin
          send_addr(DIR_READ);
          n = pick_length();
          repeat (n) ask_byte();
          close_transaction();
        end
        7: begin
          n = $urandom_range(1, 4);
          repeat (n) drive_event(3'($urandom), 1'($urandom), 8'($urandom));
        end
        default: begin
          // write then read back after a repeated start
          send_addr(DIR_WRITE);
          send_byte(pick_pointer());
          n = pick_length();
          repeat (n) send_byte(8'($urandom));
          send_addr(DIR_READ);
          n = pick_length();
          repeat (n) ask_byte();
          close_transaction();
        end
      endcase
    end

    evt.valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
